// ===== rtl/tpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpd_pkg
// Constants, types and the coordinate arithmetic shared by the decoder.
// ----------------------------------------------------------------------------
package tpd_pkg;

  localparam int CoordW = 12;   // width of coordinates, scales and limits
  localparam int ByteW  = 8;
  localparam int RawW   = 16;   // signed raw count from two report bytes
  localparam int NumW   = 30;   // signed raw * scale + rounding term
  localparam int QuotW  = NumW - 12;

  // header bytes
  localparam logic [ByteW-1:0] HDR_RELEASED = 8'h80;
  localparam logic [ByteW-1:0] HDR_PRESSED  = 8'h81;

  // touch status codes
  localparam logic [1:0] ST_NONE     = 2'd0;
  localparam logic [1:0] ST_PRESSED  = 2'd1;
  localparam logic [1:0] ST_RELEASED = 2'd2;

  // item opcodes
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_X_SCALE = 2'd0;
  localparam logic [1:0] REG_Y_SCALE = 2'd1;
  localparam logic [1:0] REG_X_LIMIT = 2'd2;
  localparam logic [1:0] REG_Y_LIMIT = 2'd3;

  // report byte phase: 0 awaits a header, 1..4 is the next data byte
  localparam logic [2:0] PHASE_HDR  = 3'd0;
  localparam logic [2:0] PHASE_LAST = 3'd4;

  typedef logic signed [QuotW-1:0] quot_t;

  // Map one coordinate's byte pair through its scale, rounding half up and
  // truncating the quotient toward zero.
  function automatic quot_t coord_calc(input logic [ByteW-1:0]  lo,
                                       input logic [ByteW-1:0]  hi,
                                       input logic [CoordW-1:0] scale);
    logic signed [RawW-1:0]   raw;
    logic signed [NumW-1:0]   num;
    quot_t                    q;
    raw = RawW'($signed(lo) >>> 1) + RawW'($signed({hi, 7'b0}));
    num = NumW'(raw * $signed({1'b0, scale})) + NumW'(2048);
    q   = num[NumW-1:12];
    // floor to truncation: step up for a negative value with a remainder
    if (num[NumW-1] && (num[11:0] != 12'd0)) begin
      q = q + QuotW'(1);
    end
    return q;
  endfunction

  // Accept when 0 <= q <= limit.
  function automatic logic in_range(input quot_t q, input logic [CoordW-1:0] limit);
    return !q[QuotW-1] && (q <= $signed({{(QuotW-CoordW){1'b0}}, limit}));
  endfunction

endpackage

// ===== rtl/touch_packet_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_packet_decoder_top
// Decoder for the 5-byte report of a resistive touch controller.
// ----------------------------------------------------------------------------
// Feed received controller bytes (tuser = 0) or a clear command (tuser = 1),
// one item per cycle. A report is a header (0x80 released, 0x81 pressed)
// followed by x low, x high, y low, y high. The fourth data byte produces one
// result item with the scaled coordinates, which are stored only when both
// fall within 0..limit; a non-header byte while awaiting a header produces a
// result with status none. Header, first three data bytes and clear produce
// no result. Each item is decoded and scaled (one 16x13 multiply per axis)
// while it sits in the input register and moves into the result register
// when the input register advances. Throughput is one item per cycle
// except while the input side stalls, which happens only while a result
// waits on the output and the input register already holds an item.
// Write the scale and limit registers only while the block is idle.
module touch_packet_decoder_top (
  input  logic        clk,
  input  logic        rst,
  // input item stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] opcode
  // result item stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [11:0] touch_x, [23:12] touch_y,
                                      // [25:24] touch_state,
                                      // [26] position_updated, [31:27] zero
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  // configuration registers
  logic [11:0] x_scale, y_scale, x_limit, y_limit;

  // input register
  logic       in_valid;
  logic       in_op;
  logic [7:0] in_byte;

  // decoder state
  logic [2:0]  byte_phase, byte_phase_next;
  logic [1:0]  pending_state, pending_state_next;
  logic [7:0]  data_bytes [3];
  logic [11:0] held_x, held_x_next;
  logic [11:0] held_y, held_y_next;
  logic [1:0]  held_state, held_state_next;

  // result register
  logic        out_valid;
  logic [11:0] out_x, out_y;
  logic [1:0]  out_state;
  logic        out_upd;

  logic advance;   // input register moves into the result stage
  logic fire;      // an item in the input register is processed this cycle
  logic emit;
  logic upd;
  logic is_hdr;
  tpd_pkg::quot_t x_q, y_q;

  // Advance whenever the result register is free or being drained.
  assign advance       = !out_valid || m_axis_tready;
  assign fire          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_scale <= 12'd770;
      y_scale <= 12'd480;
      x_limit <= 12'd800;
      y_limit <= 12'd480;
    end else if (cfg_we) begin
      case (cfg_index)
        tpd_pkg::REG_X_SCALE: x_scale <= cfg_data;
        tpd_pkg::REG_Y_SCALE: y_scale <= cfg_data;
        tpd_pkg::REG_X_LIMIT: x_limit <= cfg_data;
        tpd_pkg::REG_Y_LIMIT: y_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: capture on accept, drop once processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op   <= s_axis_tuser;
      in_byte <= s_axis_tdata;
    end
  end

  // Scale both coordinates from the stored bytes and the final byte.
  assign x_q = tpd_pkg::coord_calc(data_bytes[0], data_bytes[1], x_scale);
  assign y_q = tpd_pkg::coord_calc(data_bytes[2], in_byte, y_scale);

  assign is_hdr = (byte_phase == tpd_pkg::PHASE_HDR) || (byte_phase > tpd_pkg::PHASE_LAST);

  // Decode one item against the current state.
  always_comb begin
    byte_phase_next    = byte_phase;
    pending_state_next = pending_state;
    held_x_next        = held_x;
    held_y_next        = held_y;
    held_state_next    = held_state;
    emit               = 1'b0;
    upd                = 1'b0;
    if (in_op == tpd_pkg::OP_CLEAR) begin
      // clear leaves any report in progress running
      held_x_next     = 12'd0;
      held_y_next     = 12'd0;
      held_state_next = tpd_pkg::ST_NONE;
    end else if (is_hdr) begin
      if (in_byte == tpd_pkg::HDR_RELEASED) begin
        pending_state_next = tpd_pkg::ST_RELEASED;
        byte_phase_next    = 3'd1;
      end else if (in_byte == tpd_pkg::HDR_PRESSED) begin
        pending_state_next = tpd_pkg::ST_PRESSED;
        byte_phase_next    = 3'd1;
      end else begin
        // bad header: report status none
        byte_phase_next = tpd_pkg::PHASE_HDR;
        held_state_next = tpd_pkg::ST_NONE;
        emit            = 1'b1;
      end
    end else if (byte_phase < tpd_pkg::PHASE_LAST) begin
      byte_phase_next = byte_phase + 3'd1;
    end else begin
      // last data byte completes the report
      byte_phase_next = tpd_pkg::PHASE_HDR;
      held_state_next = pending_state;
      emit            = 1'b1;
      if (tpd_pkg::in_range(x_q, x_limit) && tpd_pkg::in_range(y_q, y_limit)) begin
        held_x_next = x_q[11:0];
        held_y_next = y_q[11:0];
        upd         = 1'b1;
      end
    end
  end

  // Decoder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase    <= tpd_pkg::PHASE_HDR;
      pending_state <= tpd_pkg::ST_NONE;
      held_x        <= 12'd0;
      held_y        <= 12'd0;
      held_state    <= tpd_pkg::ST_NONE;
    end else if (fire) begin
      byte_phase    <= byte_phase_next;
      pending_state <= pending_state_next;
      held_x        <= held_x_next;
      held_y        <= held_y_next;
      held_state    <= held_state_next;
    end
  end

  // Data byte store: first three data bytes of a report.
  always_ff @(posedge clk) begin
    if (fire && (in_op == tpd_pkg::OP_BYTE) && !is_hdr
        && (byte_phase < tpd_pkg::PHASE_LAST)) begin
      data_bytes[2'(byte_phase - 3'd1)] <= in_byte;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_x     <= held_x_next;
      out_y     <= held_y_next;
      out_state <= held_state_next;
      out_upd   <= upd;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_upd, out_state, out_y, out_x};

`ifndef ASSERT_OFF
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    byte_phase <= tpd_pkg::PHASE_LAST)
    else $error("byte phase beyond last data byte");

  a_held_state_code: assert property (@(posedge clk) disable iff (rst)
    held_state != 2'd3)
    else $error("held status holds an unused code");

  a_update_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_upd) |-> (out_x <= x_limit) && (out_y <= y_limit))
    else $error("updated position outside limits");

  a_bad_header_emits: assert property (@(posedge clk) disable iff (rst)
    (fire && (in_op == tpd_pkg::OP_BYTE) && (byte_phase == tpd_pkg::PHASE_HDR)
     && (in_byte != tpd_pkg::HDR_RELEASED) && (in_byte != tpd_pkg::HDR_PRESSED))
    |=> out_valid && (out_state == tpd_pkg::ST_NONE) && !out_upd
        && (byte_phase == tpd_pkg::PHASE_HDR))
    else $error("bad header did not produce a status-none result");
`endif

endmodule

// ===== dv/touch_packet_decoder_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_packet_decoder_top_tb
// Self-checking bench for the touch report decoder. A directed table covers
// bad headers, clear, rounding near zero and the range check. Random reports
// with noise, clears and broken reports follow under several scale and limit
// settings. Results are checked against a predictor or a typed row's result.
// ----------------------------------------------------------------------------
module touch_packet_decoder_top_tb;

  localparam int LATENCY     = 2;     // input register plus result register
  localparam int STALL_LIMIT = 1000;  // cycles with no item moving on either side
  localparam int PHASE_ITEMS = 205;   // minimum random items per register setting
  localparam int NUM_PHASES  = 6;

  // one result item, field by field
  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [1:0]  st;
    logic        upd;
  } touch_rpt_t;

  // one input item; typed rows carry their expected result
  typedef struct packed {
    logic       op;
    logic [7:0] b;
    logic       typed;
    touch_rpt_t want;
  } rx_item_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tuser  = tpd_pkg::OP_BYTE;
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [31:0] m_axis_tdata;
  logic        cfg_we        = 1'b0;
  logic [1:0]  cfg_index     = tpd_pkg::REG_X_SCALE;
  logic [11:0] cfg_data      = 12'd0;

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  touch_packet_decoder_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] rx_byte
    .s_axis_tuser  (s_axis_tuser),   // [0] opcode
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [11:0] touch_x, [23:12] touch_y,
                                     // [25:24] touch_state, [26] position_updated
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Decoder predictor: its own copy of the registers and the report state
  // --------------------------------------------------------------------------
  logic [11:0] scale_x, scale_y, lim_x, lim_y;
  logic [2:0]  rpt_phase;      // 0 awaits a header, 1..4 is the next data byte
  logic [1:0]  rpt_status;     // status announced by the current header
  logic [7:0]  rpt_bytes [3];  // x lo, x hi, y lo
  logic [11:0] hold_x, hold_y;
  logic [1:0]  hold_status;

  touch_rpt_t  due_reports [$];  // results still to arrive, oldest first
  rx_item_t    rx_items [$];     // items waiting to be driven
  touch_rpt_t  head_rpt;

  int errors        = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int updates_seen  = 0;
  int stall_left    = 0;
  int idle_cycles   = 0;
  bit quiet         = 1'b0;

  // Map a byte pair through a scale: the low byte is halved with an
  // arithmetic shift, the quotient truncates toward zero.
  function automatic longint scale_coord(input logic [7:0] lo, input logic [7:0] hi,
                                         input logic [11:0] scale);
    longint lo_s, hi_s, sc;
    lo_s = longint'($signed(lo));
    hi_s = longint'($signed(hi));
    sc   = longint'(scale);
    return (((lo_s >>> 1) + hi_s * 128) * sc + 2048) / 4096;
  endfunction

  // Advance the predictor by one accepted item.
  task automatic decode_byte(input logic op, input logic [7:0] b,
                             output bit emits, output touch_rpt_t rpt);
    longint cx, cy, lx, ly;
    emits = 1'b0;
    rpt   = '0;
    if (op == tpd_pkg::OP_CLEAR) begin
      // a report in progress keeps going
      hold_x      = 12'd0;
      hold_y      = 12'd0;
      hold_status = tpd_pkg::ST_NONE;
    end else if (rpt_phase == tpd_pkg::PHASE_HDR || rpt_phase > tpd_pkg::PHASE_LAST) begin
      if (b == tpd_pkg::HDR_RELEASED || b == tpd_pkg::HDR_PRESSED) begin
        rpt_status = (b == tpd_pkg::HDR_PRESSED) ? tpd_pkg::ST_PRESSED
                                                 : tpd_pkg::ST_RELEASED;
        rpt_phase  = 3'd1;
      end else begin
        rpt_phase   = tpd_pkg::PHASE_HDR;
        hold_status = tpd_pkg::ST_NONE;
        emits       = 1'b1;
      end
    end else if (rpt_phase < tpd_pkg::PHASE_LAST) begin
      rpt_bytes[2'(rpt_phase - 3'd1)] = b;
      rpt_phase = rpt_phase + 3'd1;
    end else begin
      cx = scale_coord(rpt_bytes[0], rpt_bytes[1], scale_x);
      cy = scale_coord(rpt_bytes[2], b, scale_y);
      lx = longint'(lim_x);
      ly = longint'(lim_y);
      rpt_phase   = tpd_pkg::PHASE_HDR;
      hold_status = rpt_status;
      emits       = 1'b1;
      // store only when both axes pass
      if (cx >= 0 && cx <= lx && cy >= 0 && cy <= ly) begin
        hold_x  = cx[11:0];
        hold_y  = cy[11:0];
        rpt.upd = 1'b1;
      end
    end
    rpt.x  = hold_x;
    rpt.y  = hold_y;
    rpt.st = hold_status;
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  task automatic queue_item(input logic op, input logic [7:0] b, input logic typed,
                            input touch_rpt_t want);
    rx_item_t it;
    it.op    = op;
    it.b     = b;
    it.typed = typed;
    it.want  = want;
    rx_items.push_back(it);
  endtask

  // Write one register; the caller lowers the write enable after the last one.
  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      tpd_pkg::REG_X_SCALE: scale_x = val;
      tpd_pkg::REG_Y_SCALE: scale_y = val;
      tpd_pkg::REG_X_LIMIT: lim_x   = val;
      default:              lim_y   = val;
    endcase
  endtask

  task automatic load_settings(input logic [11:0] xs, input logic [11:0] ys,
                               input logic [11:0] xl, input logic [11:0] yl);
    write_reg(tpd_pkg::REG_X_SCALE, xs);
    write_reg(tpd_pkg::REG_Y_SCALE, ys);
    write_reg(tpd_pkg::REG_X_LIMIT, xl);
    write_reg(tpd_pkg::REG_Y_LIMIT, yl);
    cfg_we <= 1'b0;
  endtask

  // Hold until every due result has arrived, then let the pipeline drain
  // items that produce no result.
  task automatic settle();
    while (due_reports.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // High byte of a coordinate: mostly small so that many reports land on
  // screen, sometimes anything including negative values.
  function automatic logic [7:0] pick_hi();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 40));
    return 8'($urandom);
  endfunction

  // Mostly well-formed reports with random content; the rest are noise
  // bytes, clears and reports cut short.
  task automatic queue_random_traffic(input int count);
    int n, k, len;
    n = 0;
    while (n < count) begin
      k = $urandom_range(0, 99);
      if (k < 6) begin
        queue_item(tpd_pkg::OP_CLEAR, 8'($urandom), 1'b0, '0);
        n++;
      end else if (k < 16) begin
        queue_item(tpd_pkg::OP_BYTE, 8'($urandom), 1'b0, '0);
        n++;
      end else begin
        queue_item(tpd_pkg::OP_BYTE,
                   ($urandom_range(0, 1) != 0) ? tpd_pkg::HDR_PRESSED
                                               : tpd_pkg::HDR_RELEASED,
                   1'b0, '0);
        n++;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 4;
        for (int j = 0; j < len; j++) begin
          if ($urandom_range(0, 24) == 0) begin
            queue_item(tpd_pkg::OP_CLEAR, 8'($urandom), 1'b0, '0);
            n++;
          end
          queue_item(tpd_pkg::OP_BYTE, (j % 2 == 1) ? pick_hi() : 8'($urandom),
                     1'b0, '0);
          n++;
        end
      end
    end
  endtask

  // Drive every queued item, with random gaps ahead of items when allowed.
  task automatic drive_items(input bit with_gaps);
    rx_item_t   it;
    bit         emits;
    touch_rpt_t rpt;
    while (rx_items.size() != 0) begin
      it = rx_items.pop_front();
      if (with_gaps && $urandom_range(0, 5) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tuser  <= it.op;
      s_axis_tdata  <= it.b;
      @(posedge clk);
      while (!s_axis_tready) @(posedge clk);
      decode_byte(it.op, it.b, emits, rpt);
      // typed rows stand in for the predictor's result
      if (it.typed) begin
        due_reports.push_back(it.want);
      end else if (emits) begin
        due_reports.push_back(rpt);
      end
      items_sent++;
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result side: check each accepted result, stall in random bursts
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (due_reports.size() == 0) begin
        report_mismatch($sformatf("result %h arrived with none due", m_axis_tdata));
      end else begin
        head_rpt = due_reports.pop_front();
        if (m_axis_tdata[11:0] !== head_rpt.x)
          report_mismatch($sformatf("touch_x got %0d want %0d",
                                    m_axis_tdata[11:0], head_rpt.x));
        if (m_axis_tdata[23:12] !== head_rpt.y)
          report_mismatch($sformatf("touch_y got %0d want %0d",
                                    m_axis_tdata[23:12], head_rpt.y));
        if (m_axis_tdata[25:24] !== head_rpt.st)
          report_mismatch($sformatf("touch_state got %0d want %0d",
                                    m_axis_tdata[25:24], head_rpt.st));
        if (m_axis_tdata[26] !== head_rpt.upd)
          report_mismatch($sformatf("position_updated got %0d want %0d",
                                    m_axis_tdata[26], head_rpt.upd));
        if (head_rpt.upd) updates_seen++;
      end
    end
    // random stall bursts; none in the quiet final phase
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left    <= $urandom_range(1, 18) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog: end the run when no item moves for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed table, then random traffic per setting
  // --------------------------------------------------------------------------
  initial begin
    // predictor state after reset
    scale_x     = 12'd770;
    scale_y     = 12'd480;
    lim_x       = 12'd800;
    lim_y       = 12'd480;
    rpt_phase   = tpd_pkg::PHASE_HDR;
    rpt_status  = tpd_pkg::ST_NONE;
    hold_x      = 12'd0;
    hold_y      = 12'd0;
    hold_status = tpd_pkg::ST_NONE;
    foreach (rpt_bytes[i]) rpt_bytes[i] = 8'h00;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // bad headers right after reset: status none at the origin
    queue_item(tpd_pkg::OP_BYTE, 8'h00, 1'b1, {12'd0, 12'd0, tpd_pkg::ST_NONE, 1'b0});
    queue_item(tpd_pkg::OP_BYTE, 8'hFF, 1'b1, {12'd0, 12'd0, tpd_pkg::ST_NONE, 1'b0});
    queue_item(tpd_pkg::OP_CLEAR, 8'hA5, 1'b0, '0);
    // all-zero pressed report maps to the origin and is stored
    queue_item(tpd_pkg::OP_BYTE, tpd_pkg::HDR_PRESSED, 1'b0, '0);
    queue_item(tpd_pkg::OP_BYTE, 8'h00, 1'b0, '0);
    queue_item(tpd_pkg::OP_BYTE, 8'h00, 1'b0, '0);
    queue_item(tpd_pkg::OP_BYTE, 8'h00, 1'b0, '0);
    queue_item(tpd_pkg::OP_BYTE, 8'h00, 1'b1,
               {12'd0, 12'd0, tpd_pkg::ST_PRESSED, 1'b1});
    // slightly negative raw x rounds to zero and still passes
    queue_item(tpd_pkg::OP_BYTE, tpd_pkg::HDR_RELEASED, 1'b0, '0);
    queue_item(tpd_pkg::OP_BYTE, 8'hF7, 1'b0, '0);
    queue_item(tpd_pkg::OP_BYTE, 8'h00, 1'b0, '0);
    queue_item(tpd_pkg::OP_BYTE, 8'h00, 1'b0, '0);
    queue_item(tpd_pkg::OP_BYTE, 8'h00, 1'b0, '0);
    // x far past its limit and y negative: old location is kept
    queue_item(tpd_pkg::OP_BYTE, tpd_pkg::HDR_PRESSED, 1'b0, '0);
    queue_item(tpd_pkg::OP_BYTE, 8'h7F, 1'b0, '0);
    queue_item(tpd_pkg::OP_BYTE, 8'h7F, 1'b0, '0);
    queue_item(tpd_pkg::OP_BYTE, 8'h80, 1'b0, '0);
    queue_item(tpd_pkg::OP_BYTE, 8'h80, 1'b0, '0);
    // clear inside a report; header-valued data bytes; report still completes
    queue_item(tpd_pkg::OP_BYTE, tpd_pkg::HDR_RELEASED, 1'b0, '0);
    queue_item(tpd_pkg::OP_BYTE, 8'h81, 1'b0, '0);
    queue_item(tpd_pkg::OP_BYTE, 8'h04, 1'b0, '0);
    queue_item(tpd_pkg::OP_CLEAR, 8'h5A, 1'b0, '0);
    queue_item(tpd_pkg::OP_BYTE, 8'h80, 1'b0, '0);
    queue_item(tpd_pkg::OP_BYTE, 8'h08, 1'b0, '0);
    // clear then a bad header: zeroed location, status none
    queue_item(tpd_pkg::OP_CLEAR, 8'hFF, 1'b0, '0);
    queue_item(tpd_pkg::OP_BYTE, 8'h7E, 1'b1, {12'd0, 12'd0, tpd_pkg::ST_NONE, 1'b0});

    // random traffic under the reset settings follows the table directly
    queue_random_traffic(PHASE_ITEMS);
    drive_items(1'b1);

    for (int p = 1; p < NUM_PHASES; p++) begin
      settle();
      case (p)
        1:       load_settings(12'd4095, 12'd4095, 12'd4095, 12'd4095);
        2:       load_settings(12'd1, 12'd1, 12'd0, 12'd0);
        3:       load_settings(12'd4095, 12'd1, 12'd0, 12'd4095);
        4:       load_settings(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)),
                               12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
        default: load_settings(12'd770, 12'd480, 12'd800, 12'd480);
      endcase
      // last phase runs flat out on both sides
      if (p == NUM_PHASES - 1) quiet = 1'b1;
      queue_random_traffic(PHASE_ITEMS);
      drive_items(!quiet);
    end

    settle();
    $display("Drove %0d input items over %0d register settings.", items_sent, NUM_PHASES);
    $display("Checked %0d results, %0d of them with a stored position; %0d errors.",
             results_seen, updates_seen, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
